### rtl/core/sitda_pkg.sv
// Package for the signed integer to decimal ASCII core.
// Holds widths, character codes and the controller/datapath interface structs.
// No dependencies.
package sitda_pkg;

    localparam int VALUE_BITS  = 64;
    localparam int TDATA_IN_W  = 64;
    localparam int CHAR_W      = 8;
    localparam int NUM_DIGITS  = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
    localparam int BIT_CNT_W   = $clog2(VALUE_BITS);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic load;
        logic shift;
        logic dec_idx;
        logic put_minus;
        logic put_digit;
    } sitda_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic negative;
        logic digit_zero;
        logic idx_zero;
    } sitda_stat_t;

endpackage

### rtl/core/sitda_dp.sv
// Datapath: magnitude and BCD registers (shift-and-add-3), digit pointer, output register.
// Depends on sitda_pkg; driven by sitda_ctrl through sitda_cmd_t.
module sitda_dp (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic [sitda_pkg::TDATA_IN_W-1:0]        s_tdata,
    input  sitda_pkg::sitda_cmd_t                   cmd,
    output sitda_pkg::sitda_stat_t                  stat,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [sitda_pkg::CHAR_W-1:0]            m_tdata,
    output logic                                    m_tlast
);
    import sitda_pkg::*;

    logic [VALUE_BITS-1:0]  raw;
    logic [VALUE_BITS-1:0]  mag_in;
    logic [VALUE_BITS-1:0]  mag_reg;
    logic                   neg_reg;
    logic [3:0]             bcd_reg [NUM_DIGITS];
    logic [3:0]             adj     [NUM_DIGITS];
    logic [DIGIT_IDX_W-1:0] idx_reg;
    logic [3:0]             digit_cur;
    logic                   out_valid_reg;
    logic [CHAR_W-1:0]      out_char_reg;
    logic                   out_last_reg;

    assign raw    = s_tdata[VALUE_BITS-1:0];
    assign mag_in = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? (bcd_reg[i] + 4'd3) : bcd_reg[i];
        end
    end

    assign digit_cur = bcd_reg[idx_reg];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mag_reg <= mag_in;
            neg_reg <= raw[VALUE_BITS-1];
            idx_reg <= DIGIT_IDX_W'(NUM_DIGITS - 1);
            for (int i = 0; i < NUM_DIGITS; i++) begin
                bcd_reg[i] <= '0;
            end
        end else if (cmd.shift) begin
            mag_reg    <= {mag_reg[VALUE_BITS-2:0], 1'b0};
            bcd_reg[0] <= {adj[0][2:0], mag_reg[VALUE_BITS-1]};
            for (int i = 1; i < NUM_DIGITS; i++) begin
                bcd_reg[i] <= {adj[i][2:0], adj[i-1][3]};
            end
        end else if (cmd.dec_idx || cmd.put_digit) begin
            if (idx_reg != '0) begin
                idx_reg <= idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.put_minus || cmd.put_digit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.put_minus) begin
            out_char_reg <= CHAR_MINUS;
            out_last_reg <= 1'b0;
        end else if (cmd.put_digit) begin
            out_char_reg <= CHAR_ZERO + {4'd0, digit_cur};
            out_last_reg <= (idx_reg == '0);
        end
    end

    assign stat.slot_free  = !out_valid_reg || m_tready;
    assign stat.negative   = neg_reg;
    assign stat.digit_zero = (digit_cur == 4'd0);
    assign stat.idx_zero   = (idx_reg == '0);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_char_reg == CHAR_MINUS) |-> !out_last_reg)
        else $error("minus sign flagged as last character");

    a_char_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_char_reg == CHAR_MINUS ||
                           (out_char_reg >= CHAR_ZERO && out_char_reg <= CHAR_NINE)))
        else $error("illegal output character");

    a_load_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (bcd_reg[0] == 4'd0 && idx_reg == DIGIT_IDX_W'(NUM_DIGITS - 1)))
        else $error("load did not clear BCD state");

endmodule

### rtl/core/sitda_ctrl.sv
// Controller: sequences load, bit-serial conversion, leading-zero skip and character emission.
// Depends on sitda_pkg; commands sitda_dp, reads its status.
module sitda_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  sitda_pkg::sitda_stat_t stat,
    output sitda_pkg::sitda_cmd_t  cmd
);
    import sitda_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [BIT_CNT_W-1:0] cnt_reg, cnt_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = BIT_CNT_W'(VALUE_BITS - 1);
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.shift = 1'b1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (stat.digit_zero && !stat.idx_zero) begin
                    cmd.dec_idx = 1'b1;
                end else if (stat.negative) begin
                    state_next = ST_SIGN;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (stat.slot_free) begin
                    cmd.put_minus = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.slot_free) begin
                    cmd.put_digit = 1'b1;
                    if (stat.idx_zero) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.shift, cmd.dec_idx, cmd.put_minus, cmd.put_digit}))
        else $error("more than one datapath command");

    a_put_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.put_minus || cmd.put_digit) |-> stat.slot_free)
        else $error("output register overwritten");

    a_conv_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV && cnt_reg != '0) |=> state_reg == ST_CONV)
        else $error("conversion left early");

    a_load_to_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_CONV && cnt_reg == BIT_CNT_W'(VALUE_BITS - 1)))
        else $error("conversion not started after load");

endmodule

### rtl/core/signed_int_to_decimal_ascii_core.sv
// Channel   Dir  Payload                         Marker
// s_        in   tdata[63:0] value (signed)      -
// m_        out  tdata[7:0]  text_char           tlast = last_char
//
// One number at a time: an accept step, a shift-and-add-3 step for each of the VALUE_BITS
// bits into the BCD register, a scan that suppresses leading zeros (up to 19) and then
// leaves, then the characters, sign first, one by one. Suppressed zeros and emitted digits
// always total 20; a minus sign adds one character.
// Reset: synchronous, active-low aresetn; clears controller state and output valid.
// m_tready low holds the output register and stalls the character sequence.
// Depends on sitda_pkg, sitda_ctrl, sitda_dp.
module signed_int_to_decimal_ascii_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sitda_pkg::TDATA_IN_W-1:0]  s_tdata,   // [63:0] value
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sitda_pkg::CHAR_W-1:0]      m_tdata,   // [7:0] text_char
    output logic                              m_tlast
);
    import sitda_pkg::*;

    sitda_cmd_t  cmd;
    sitda_stat_t stat;

    sitda_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sitda_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
